FILE: hdl/swsfd_pkg.sv
// Shared types and constants for the single-wire sensor frame decoder.
// No dependencies; imported by the decoder top level.
`default_nettype none

package swsfd_pkg;

	localparam int DATA_BITS  = 40;
	localparam int DUR_W      = 15;
	localparam int RAW_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic [DUR_W-1:0] BIT_ONE_THRESHOLD_RST = 15'd40;
	localparam logic [DUR_W-1:0] LOW_PHASE_MIN_RST     = 15'd20;
	localparam logic [DUR_W-1:0] LOW_PHASE_MAX_RST     = 15'd100;

	localparam logic [BYTE_W-1:0] CSUM_FLIP = 8'h01;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIT_ONE_THRESHOLD = 2'd0,
		CFG_LOW_PHASE_MIN     = 2'd1,
		CFG_LOW_PHASE_MAX     = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_FRAMING  = 2'd2,
		ST_CHECKSUM = 2'd3
	} status_t;

endpackage

`default_nettype wire

FILE: hdl/single_wire_sensor_frame_decoder.sv
// Single-wire sensor frame decoder: input register, symbol decode and result register.
// Depends on swsfd_pkg for field widths, register indexes and status codes.
`default_nettype none

// Takes one captured pulse symbol per cycle. A transfer on the input is registered, then
// decoded against the frame state from that register; a symbol marked frame_end loads the
// result register, which then raises out_valid. The
// input stalls only while a completed frame's symbol waits for the result register,
// which is held until the downstream side takes it. Header symbols are skipped, the
// next 40 are checked and shifted in, later ones are ignored. Status is
// 0 ok, 1 too few symbols, 2 bit framing error, 3 checksum failed; reading and
// recovery flag are zero unless status is ok. Write registers only while idle.
module single_wire_sensor_frame_decoder
	import swsfd_pkg::*;
#(
	parameter int HEADER_SYMBOLS = 2
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_write,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [DUR_W-1:0]        cfg_data,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire                    first_level,
	input  wire [DUR_W-1:0]        first_duration,
	input  wire [DUR_W-1:0]        second_duration,
	input  wire                    frame_end,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [1:0]             status,
	output logic [RAW_W-1:0]       raw_value,
	output logic                   last_bit_recovered
);

	localparam int FRAME_SYMBOLS = HEADER_SYMBOLS + DATA_BITS;
	localparam int CNT_W         = $clog2(FRAME_SYMBOLS + 1);
	localparam logic [CNT_W-1:0] HDR_CNT   = CNT_W'(HEADER_SYMBOLS);
	localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_SYMBOLS);

	logic [DUR_W-1:0] bit_one_threshold_q;
	logic [DUR_W-1:0] low_phase_min_q;
	logic [DUR_W-1:0] low_phase_max_q;

	logic             valid_s1;
	logic             level_s1;
	logic [DUR_W-1:0] dur0_s1;
	logic [DUR_W-1:0] dur1_s1;
	logic             end_s1;

	logic [CNT_W-1:0]     count_q;
	logic [DATA_BITS-1:0] shift_q;
	logic                 bad_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [RAW_W-1:0] raw_q;
	logic             rec_q;

	logic                 out_free;
	logic                 advance;
	logic                 in_accept;
	logic                 in_data;
	logic [CNT_W-1:0]     count_nxt;
	logic [DATA_BITS-1:0] shift_nxt;
	logic                 bad_nxt;
	logic [BYTE_W-1:0]    b0, b1, b2, b3, b4, sum;
	status_t              status_nxt;
	logic [RAW_W-1:0]     raw_nxt;
	logic                 rec_nxt;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && (!end_s1 || out_free);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_one_threshold_q <= BIT_ONE_THRESHOLD_RST;
			low_phase_min_q     <= LOW_PHASE_MIN_RST;
			low_phase_max_q     <= LOW_PHASE_MAX_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BIT_ONE_THRESHOLD: bit_one_threshold_q <= cfg_data;
				CFG_LOW_PHASE_MIN:     low_phase_min_q     <= cfg_data;
				CFG_LOW_PHASE_MAX:     low_phase_max_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			level_s1 <= first_level;
			dur0_s1  <= first_duration;
			dur1_s1  <= second_duration;
			end_s1   <= frame_end;
		end
	end

	always_comb begin
		in_data   = (count_q >= HDR_CNT) && (count_q < FRAME_CNT);
		count_nxt = (count_q < FRAME_CNT) ? count_q + CNT_W'(1) : count_q;
		shift_nxt = shift_q;
		bad_nxt   = bad_q;
		if (in_data) begin
			shift_nxt = {shift_q[DATA_BITS-2:0], (dur1_s1 >= bit_one_threshold_q)};
			if (level_s1 || (dur0_s1 < low_phase_min_q) || (dur0_s1 > low_phase_max_q)) begin
				bad_nxt = 1'b1;
			end
		end
		b0  = shift_nxt[39:32];
		b1  = shift_nxt[31:24];
		b2  = shift_nxt[23:16];
		b3  = shift_nxt[15:8];
		b4  = shift_nxt[7:0];
		sum = b0 + b1 + b2 + b3;
		status_nxt = ST_OK;
		raw_nxt    = '0;
		rec_nxt    = 1'b0;
		if (count_nxt < FRAME_CNT) begin
			status_nxt = ST_SHORT;
		end else if (bad_nxt) begin
			status_nxt = ST_FRAMING;
		end else if (b4 == sum) begin
			raw_nxt = {b0, b1};
		end else if ((b4 ^ CSUM_FLIP) == sum) begin
			raw_nxt = {b0, b1};
			rec_nxt = 1'b1;
		end else begin
			status_nxt = ST_CHECKSUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			shift_q <= '0;
			bad_q   <= 1'b0;
		end else if (advance) begin
			if (end_s1) begin
				count_q <= '0;
				shift_q <= '0;
				bad_q   <= 1'b0;
			end else begin
				count_q <= count_nxt;
				shift_q <= shift_nxt;
				bad_q   <= bad_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			status_q <= status_nxt;
			raw_q    <= raw_nxt;
			rec_q    <= rec_nxt;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign raw_value          = raw_q;
	assign last_bit_recovered = rec_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && end_s1 && out_valid_q && out_stall))
		else $error("input stalled without a waiting frame result");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && end_s1) |=> (count_q == '0 && shift_q == '0 && !bad_q))
		else $error("frame state not cleared after result");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FRAME_CNT)
		else $error("symbol count beyond frame length");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (raw_q == '0 && !rec_q))
		else $error("failed frame carries a reading");

endmodule

`default_nettype wire

FILE: verif/tb_single_wire_sensor_frame_decoder.sv
`timescale 1ns / 1ps
// Testbench for the single-wire sensor frame decoder: directed symbols, then random
// frames under several register settings, checked against a frame predictor.
// Depends on swsfd_pkg and single_wire_sensor_frame_decoder.
module tb_single_wire_sensor_frame_decoder;
	import swsfd_pkg::*;

	localparam int HDR = 2;
	localparam int FRAME_SYMS = HDR + DATA_BITS;
	localparam logic [DUR_W-1:0] DUR_MAX = '1;
	localparam int PHASE_SYMS = 230;
	localparam int NUM_PHASES = 7;

	typedef struct {
		logic level;
		logic [DUR_W-1:0] d0;
		logic [DUR_W-1:0] d1;
		logic fin;
	} symbol_t;

	typedef struct {
		status_t st;
		logic [RAW_W-1:0] raw;
		logic rec;
	} reading_t;

	typedef enum { FK_GOOD, FK_RECOVER, FK_BAD_SUM, FK_FRAMING, FK_SHORT, FK_NOISE } frame_kind_t;
	typedef enum { RX_FREE, RX_RANDOM, RX_RUNS } stall_mode_t;

	class frame_scoreboard;
		logic [DUR_W-1:0] one_thr;
		logic [DUR_W-1:0] low_min;
		logic [DUR_W-1:0] low_max;
		int unsigned sym_count;
		logic [DATA_BITS-1:0] shift_bits;
		bit framing_bad;
		reading_t readings[$];
		int unsigned errors;

		function new();
			one_thr = BIT_ONE_THRESHOLD_RST;
			low_min = LOW_PHASE_MIN_RST;
			low_max = LOW_PHASE_MAX_RST;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			sym_count = 0;
			shift_bits = '0;
			framing_bad = 1'b0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [DUR_W-1:0] v);
			case (idx)
				CFG_BIT_ONE_THRESHOLD: one_thr = v;
				CFG_LOW_PHASE_MIN: low_min = v;
				CFG_LOW_PHASE_MAX: low_max = v;
				default: ;
			endcase
		endfunction

		function void note_symbol(symbol_t s);
			reading_t r;
			logic [BYTE_W-1:0] b0, b1, b2, b3, b4, csum;
			if (sym_count >= HDR && sym_count < FRAME_SYMS) begin
				if (s.level || s.d0 < low_min || s.d0 > low_max)
					framing_bad = 1'b1;
				shift_bits = {shift_bits[DATA_BITS-2:0], s.d1 >= one_thr};
			end
			if (sym_count < FRAME_SYMS)
				sym_count++;
			if (s.fin) begin
				{b0, b1, b2, b3, b4} = shift_bits;
				csum = b0 + b1 + b2 + b3;
				r.st = ST_OK;
				r.raw = '0;
				r.rec = 1'b0;
				if (sym_count < FRAME_SYMS)
					r.st = ST_SHORT;
				else if (framing_bad)
					r.st = ST_FRAMING;
				else if (b4 == csum)
					r.raw = {b0, b1};
				else if ((b4 ^ CSUM_FLIP) == csum) begin
					r.raw = {b0, b1};
					r.rec = 1'b1;
				end else
					r.st = ST_CHECKSUM;
				readings.push_back(r);
				clear_frame();
			end
		endfunction

		task report(string msg);
			$display("%0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_result(status_t st, logic [RAW_W-1:0] raw, logic rec);
			reading_t want;
			if (readings.size() == 0) begin
				report($sformatf("result with nothing expected: status %0d raw %h", st, raw));
				return;
			end
			want = readings.pop_front();
			if (st !== want.st)
				report($sformatf("status %0d, expected %0d", st, want.st));
			if (raw !== want.raw)
				report($sformatf("raw_value %h, expected %h", raw, want.raw));
			if (rec !== want.rec)
				report($sformatf("last_bit_recovered %b, expected %b", rec, want.rec));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DUR_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic first_level;
	logic [DUR_W-1:0] first_duration;
	logic [DUR_W-1:0] second_duration;
	logic frame_end;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [RAW_W-1:0] raw_value;
	logic last_bit_recovered;

	frame_scoreboard sb;
	symbol_t sym_q[$];
	int burst_left = 0;
	int rx_clock = 0;
	int rx_run = 0;
	bit rx_hold = 1'b0;
	stall_mode_t rx_mode = RX_FREE;

	single_wire_sensor_frame_decoder #(
		.HEADER_SYMBOLS(HDR)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_level(first_level),
		.first_duration(first_duration),
		.second_duration(second_duration),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.raw_value(raw_value),
		.last_bit_recovered(last_bit_recovered)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [DUR_W-1:0] low_dur();
		case ($urandom_range(0, 3))
			0: return sb.low_min;
			1: return sb.low_max;
			default: return DUR_W'($urandom_range(sb.low_min, sb.low_max));
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] bit_dur(logic one);
		if (one)
			return ($urandom_range(0, 3) == 0) ? sb.one_thr
				: DUR_W'($urandom_range(sb.one_thr, DUR_MAX));
		if (sb.one_thr == 0)
			return '0;
		return ($urandom_range(0, 3) == 0) ? sb.one_thr - 1'b1
			: DUR_W'($urandom_range(0, sb.one_thr - 1));
	endfunction

	function automatic symbol_t noise_symbol();
		symbol_t s;
		s.level = 1'($urandom_range(0, 1));
		s.d0 = DUR_W'($urandom_range(0, DUR_MAX));
		s.d1 = DUR_W'($urandom_range(0, DUR_MAX));
		s.fin = 1'b0;
		return s;
	endfunction

	function automatic void queue_symbol(logic level, logic [DUR_W-1:0] d0,
			logic [DUR_W-1:0] d1, logic fin);
		symbol_t s;
		s.level = level;
		s.d0 = d0;
		s.d1 = d1;
		s.fin = fin;
		sym_q.push_back(s);
	endfunction

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return FK_GOOD;
		if (r < 45)
			return FK_RECOVER;
		if (r < 60)
			return FK_BAD_SUM;
		if (r < 72)
			return FK_FRAMING;
		if (r < 87)
			return FK_SHORT;
		return FK_NOISE;
	endfunction

	function automatic void queue_frame(frame_kind_t kind);
		symbol_t fr[$];
		symbol_t s;
		logic [BYTE_W-1:0] b0, b1, b2, b3, b4;
		logic [DATA_BITS-1:0] word;
		int n;
		int pos;
		if (kind == FK_NOISE) begin
			n = $urandom_range(1, 60);
			repeat (n) begin
				s = noise_symbol();
				s.fin = ($urandom_range(0, 11) == 0);
				fr.push_back(s);
			end
		end else begin
			b0 = BYTE_W'($urandom);
			b1 = BYTE_W'($urandom);
			b2 = BYTE_W'($urandom);
			b3 = BYTE_W'($urandom);
			b4 = b0 + b1 + b2 + b3;
			if (kind == FK_RECOVER)
				b4 = b4 ^ CSUM_FLIP;
			if (kind == FK_BAD_SUM)
				b4 = b4 ^ BYTE_W'($urandom_range(2, 255));
			word = {b0, b1, b2, b3, b4};
			repeat (HDR)
				fr.push_back(noise_symbol());
			for (int i = DATA_BITS - 1; i >= 0; i--) begin
				s.level = 1'b0;
				s.d0 = low_dur();
				s.d1 = bit_dur(word[i]);
				s.fin = 1'b0;
				fr.push_back(s);
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 30))
					fr.push_back(noise_symbol());
			if (kind == FK_FRAMING) begin
				repeat ($urandom_range(1, 3)) begin
					pos = HDR + $urandom_range(0, DATA_BITS - 1);
					case ($urandom_range(0, 2))
						0: fr[pos].level = 1'b1;
						1: begin
							if (sb.low_min > 0)
								fr[pos].d0 = DUR_W'($urandom_range(0, sb.low_min - 1));
							else
								fr[pos].level = 1'b1;
						end
						default: begin
							if (sb.low_max < DUR_MAX)
								fr[pos].d0 = DUR_W'($urandom_range(sb.low_max + 1, DUR_MAX));
							else
								fr[pos].level = 1'b1;
						end
					endcase
				end
			end
			if (kind == FK_SHORT) begin
				n = $urandom_range(1, FRAME_SYMS - 1);
				fr = fr[0:n-1];
			end
		end
		fr[fr.size()-1].fin = 1'b1;
		foreach (fr[i])
			sym_q.push_back(fr[i]);
	endfunction

	task automatic run_symbols();
		symbol_t s;
		int gap;
		while (sym_q.size() > 0) begin
			s = sym_q.pop_front();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			first_level <= s.level;
			first_duration <= s.d0;
			second_duration <= s.d1;
			frame_end <= s.fin;
			in_valid <= 1'b1;
			do @(posedge clk); while (in_stall);
			sb.note_symbol(s);
		end
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.readings.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic [DUR_W-1:0] thr, logic [DUR_W-1:0] mn,
			logic [DUR_W-1:0] mx);
		cfg_write <= 1'b1;
		cfg_index <= CFG_BIT_ONE_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		sb.set_register(CFG_BIT_ONE_THRESHOLD, thr);
		cfg_index <= CFG_LOW_PHASE_MIN;
		cfg_data <= mn;
		@(posedge clk);
		sb.set_register(CFG_LOW_PHASE_MIN, mn);
		cfg_index <= CFG_LOW_PHASE_MAX;
		cfg_data <= mx;
		@(posedge clk);
		sb.set_register(CFG_LOW_PHASE_MAX, mx);
		cfg_write <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status_t'(status), raw_value, last_bit_recovered);
		rx_clock++;
		if (rx_clock % 256 == 0)
			rx_mode = stall_mode_t'($urandom_range(0, 2));
		case (rx_mode)
			RX_FREE: out_stall <= 1'b0;
			RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
			default: begin
				if (rx_run == 0) begin
					rx_run = $urandom_range(1, 20);
					rx_hold = !rx_hold;
				end
				rx_run--;
				out_stall <= rx_hold;
			end
		endcase
	end

	initial begin
		logic [DUR_W-1:0] mn;
		logic [DUR_W-1:0] mx;
		sb = new();
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_BIT_ONE_THRESHOLD;
		cfg_data <= '0;
		in_valid <= 1'b0;
		first_level <= 1'b0;
		first_duration <= '0;
		second_duration <= '0;
		frame_end <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone symbols, header-only and one-bit frames with extreme fields
		queue_symbol(1'b0, '0, '0, 1'b1);
		queue_symbol(1'b1, DUR_MAX, DUR_MAX, 1'b1);
		queue_symbol(1'b1, DUR_MAX, '0, 1'b0);
		queue_symbol(1'b0, '0, DUR_MAX, 1'b1);
		queue_symbol(1'b0, '0, '0, 1'b0);
		queue_symbol(1'b1, 15'h2AAA, 15'h5555, 1'b0);
		queue_symbol(1'b0, LOW_PHASE_MIN_RST, BIT_ONE_THRESHOLD_RST, 1'b1);
		queue_symbol(1'b0, 15'h5555, 15'h2AAA, 1'b0);
		queue_symbol(1'b1, '0, DUR_MAX, 1'b0);
		queue_symbol(1'b0, LOW_PHASE_MAX_RST, BIT_ONE_THRESHOLD_RST - 1'b1, 1'b0);
		queue_symbol(1'b0, LOW_PHASE_MIN_RST - 1'b1, DUR_MAX, 1'b0);
		queue_symbol(1'b1, DUR_MAX, '0, 1'b1);
		queue_symbol(1'b0, '0, '0, 1'b1);
		run_symbols();
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: ;
				1: set_config('0, '0, DUR_MAX);
				2: set_config(DUR_MAX, DUR_MAX, DUR_MAX);
				3: set_config(15'd1, '0, '0);
				4: begin
					mn = DUR_W'($urandom_range(1, DUR_MAX));
					set_config(DUR_W'($urandom_range(1, DUR_MAX)), mn,
						DUR_W'($urandom_range(0, mn - 1)));
				end
				5: begin
					mn = DUR_W'($urandom_range(0, 200));
					set_config(DUR_W'($urandom_range(1, 200)), mn,
						mn + DUR_W'($urandom_range(0, 300)));
				end
				default: begin
					mn = DUR_W'($urandom_range(0, DUR_MAX));
					mx = DUR_W'($urandom_range(mn, DUR_MAX));
					set_config(DUR_W'($urandom_range(0, DUR_MAX)), mn, mx);
				end
			endcase
			queue_frame(FK_GOOD);
			queue_frame(FK_RECOVER);
			queue_frame(FK_BAD_SUM);
			queue_frame(FK_FRAMING);
			queue_frame(FK_SHORT);
			queue_frame(FK_NOISE);
			while (sym_q.size() < PHASE_SYMS)
				queue_frame(pick_kind());
			run_symbols();
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_single_wire_sensor_frame_decoder passed");
		else
			$display("tb_single_wire_sensor_frame_decoder failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_single_wire_sensor_frame_decoder failed");
		$finish;
	end

endmodule

FILE: files.f
hdl/swsfd_pkg.sv
hdl/single_wire_sensor_frame_decoder.sv
verif/tb_single_wire_sensor_frame_decoder.sv
